// ===== rtl/clsc_pkg.sv =====
// Shared constants, control-word types and the microcode table of the least-squares check.
package clsc_pkg;

    // Default store sizes
    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_MAX_COLS = 16;

    // Field widths
    localparam int MODE_W = 2;
    localparam int IDX_W  = 8;
    localparam int VAL_W  = 64;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 5;
    localparam int CFG_IDX_W = 1;
    localparam int HALF_W = VAL_W / 2;
    localparam int PROD_W = 2 * VAL_W;

    // Input item modes
    localparam logic [MODE_W-1:0] MODE_WR_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WR_X  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WR_B  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CHECK = 2'd3;

    // Result codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FAIL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVF  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DIM  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    // Microcode addresses
    localparam int UPC_W = 5;
    localparam logic [UPC_W-1:0] UPC_IDLE  = 5'd0;
    localparam logic [UPC_W-1:0] UPC_START = 5'd1;
    localparam logic [UPC_W-1:0] UPC_ROW1  = 5'd2;
    localparam logic [UPC_W-1:0] UPC_RD1   = 5'd3;
    localparam logic [UPC_W-1:0] UPC_LD1   = 5'd4;
    localparam logic [UPC_W-1:0] UPC_M0_1  = 5'd5;
    localparam logic [UPC_W-1:0] UPC_M1_1  = 5'd6;
    localparam logic [UPC_W-1:0] UPC_M2_1  = 5'd7;
    localparam logic [UPC_W-1:0] UPC_M3_1  = 5'd8;
    localparam logic [UPC_W-1:0] UPC_MF_1  = 5'd9;
    localparam logic [UPC_W-1:0] UPC_SG_1  = 5'd10;
    localparam logic [UPC_W-1:0] UPC_AC_1  = 5'd11;
    localparam logic [UPC_W-1:0] UPC_RS_1  = 5'd12;
    localparam logic [UPC_W-1:0] UPC_ST2   = 5'd13;
    localparam logic [UPC_W-1:0] UPC_ROW2  = 5'd14;
    localparam logic [UPC_W-1:0] UPC_RD2   = 5'd15;
    localparam logic [UPC_W-1:0] UPC_LD2   = 5'd16;
    localparam logic [UPC_W-1:0] UPC_M0_2  = 5'd17;
    localparam logic [UPC_W-1:0] UPC_M1_2  = 5'd18;
    localparam logic [UPC_W-1:0] UPC_M2_2  = 5'd19;
    localparam logic [UPC_W-1:0] UPC_M3_2  = 5'd20;
    localparam logic [UPC_W-1:0] UPC_MF_2  = 5'd21;
    localparam logic [UPC_W-1:0] UPC_SG_2  = 5'd22;
    localparam logic [UPC_W-1:0] UPC_AC_2  = 5'd23;
    localparam logic [UPC_W-1:0] UPC_NZ_2  = 5'd24;
    localparam logic [UPC_W-1:0] UPC_DONE  = 5'd25;

    // Product register update
    typedef enum logic [2:0] {
        PROD_HOLD,
        PROD_CLR,
        PROD_ADD0,
        PROD_ADD32,
        PROD_ADD64
    } prod_op_t;

    // Operand halves fed to the 32x32 multiplier: first letter A side, second vector side
    typedef enum logic [1:0] {
        HALF_LL,
        HALF_LH,
        HALF_HL,
        HALF_HH
    } half_t;

    // Matrix address register update
    typedef enum logic [2:0] {
        ADDR_HOLD,
        ADDR_ZERO,
        ADDR_INC1,
        ADDR_SET_I,
        ADDR_ADD_N
    } addr_op_t;

    // Vector operand source
    typedef enum logic {
        VSEL_X,
        VSEL_R
    } vsel_t;

    // Branch conditions
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_DIM_ZERO,
        COND_J_MORE_N,
        COND_J_MORE_M,
        COND_I_MORE_M,
        COND_I_MORE_N
    } cond_t;

    // One control word
    typedef struct packed {
        logic             clr_acc;
        logic             clr_j;
        logic             inc_j;
        logic             clr_i;
        logic             inc_i;
        logic             clr_flags;
        logic             ld;
        vsel_t            vsel;
        half_t            half;
        prod_op_t         prod_op;
        logic             sgn;
        logic             acc_add;
        logic             res_wr;
        logic             nz_chk;
        logic             done;
        addr_op_t         addr_op;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } ctrl_t;

    // Microcode ROM
    function automatic ctrl_t ucode(input logic [UPC_W-1:0] upc);
        ctrl_t w;
        w = ctrl_t'('0);
        unique case (upc) inside
            UPC_START: begin
                w.clr_flags = 1'b1;
                w.clr_i     = 1'b1;
                w.addr_op   = ADDR_ZERO;
                w.cond      = COND_DIM_ZERO;
                w.target    = UPC_DONE;
            end
            UPC_ROW1: begin
                w.clr_acc = 1'b1;
                w.clr_j   = 1'b1;
            end
            UPC_LD1: begin
                w.ld   = 1'b1;
                w.vsel = VSEL_X;
            end
            UPC_LD2: begin
                w.ld   = 1'b1;
                w.vsel = VSEL_R;
            end
            UPC_M0_1, UPC_M0_2: begin
                w.half    = HALF_LL;
                w.prod_op = PROD_CLR;
            end
            UPC_M1_1, UPC_M1_2: begin
                w.half    = HALF_LH;
                w.prod_op = PROD_ADD0;
            end
            UPC_M2_1, UPC_M2_2: begin
                w.half    = HALF_HL;
                w.prod_op = PROD_ADD32;
            end
            UPC_M3_1, UPC_M3_2: begin
                w.half    = HALF_HH;
                w.prod_op = PROD_ADD32;
            end
            UPC_MF_1, UPC_MF_2: begin
                w.prod_op = PROD_ADD64;
            end
            UPC_SG_1, UPC_SG_2: begin
                w.sgn = 1'b1;
            end
            UPC_AC_1: begin
                w.acc_add = 1'b1;
                w.inc_j   = 1'b1;
                w.addr_op = ADDR_INC1;
                w.cond    = COND_J_MORE_N;
                w.target  = UPC_RD1;
            end
            UPC_RS_1: begin
                w.res_wr = 1'b1;
                w.inc_i  = 1'b1;
                w.cond   = COND_I_MORE_M;
                w.target = UPC_ROW1;
            end
            UPC_ST2: begin
                w.clr_i = 1'b1;
            end
            UPC_ROW2: begin
                w.clr_acc = 1'b1;
                w.clr_j   = 1'b1;
                w.addr_op = ADDR_SET_I;
            end
            UPC_AC_2: begin
                w.acc_add = 1'b1;
                w.inc_j   = 1'b1;
                w.addr_op = ADDR_ADD_N;
                w.cond    = COND_J_MORE_M;
                w.target  = UPC_RD2;
            end
            UPC_NZ_2: begin
                w.nz_chk = 1'b1;
                w.inc_i  = 1'b1;
                w.cond   = COND_I_MORE_N;
                w.target = UPC_ROW2;
            end
            UPC_DONE: begin
                w.done = 1'b1;
            end
            default: begin
                w = ctrl_t'('0);
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/checked_least_squares_check.sv =====
// Top level of the least-squares normal-equation check: stores, microcode sequencer, datapath.
// Write items (A, x, b elements) give no result, and the block stays ready for the next item.
// A check item runs the microcode from transfer to result; each multiply-accumulate costs
// nine steps, set by the one shared 32x32 multiplier that builds every 64x64 product from
// four partial products.  A zero dimension skips straight to the result step.
// The block takes no item while a check runs; a result waits in an output register.
// Reset: row_count = col_count = 1, sequencer idle, no result pending; stores undefined.
module checked_least_squares_check #(
    parameter int MAX_ROWS = clsc_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = clsc_pkg::DEF_MAX_COLS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [clsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [clsc_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [clsc_pkg::MODE_W-1:0]     mode,
    input  logic [clsc_pkg::IDX_W-1:0]      element_index,
    input  logic signed [clsc_pkg::VAL_W-1:0] element_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [clsc_pkg::STAT_W-1:0]     status
);

    localparam int VW        = clsc_pkg::VAL_W;
    localparam int HW        = clsc_pkg::HALF_W;
    localparam int PW        = clsc_pkg::PROD_W;
    localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int MA_W      = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
    localparam int XA_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RA_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int MAX_DIM   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int CNT_W     = $clog2(MAX_DIM + 1);

    // Stores and their registered read data
    logic [VW-1:0] mat_mem [MAT_DEPTH];
    logic [VW-1:0] x_mem   [MAX_COLS];
    logic [VW-1:0] b_mem   [MAX_ROWS];
    logic [VW-1:0] r_mem   [MAX_ROWS];
    logic [VW-1:0] mat_rd_reg;
    logic [VW-1:0] x_rd_reg;
    logic [VW-1:0] b_rd_reg;
    logic [VW-1:0] r_rd_reg;

    // Control state
    logic [clsc_pkg::UPC_W-1:0] upc_reg, upc_next;
    logic [clsc_pkg::CFG_W-1:0] row_count_reg, col_count_reg;
    logic [CNT_W-1:0]           i_reg, i_next;
    logic [CNT_W-1:0]           j_reg, j_next;
    logic [MA_W-1:0]            addr_reg, addr_next;
    logic                       ovf_reg, ovf_next;
    logic                       zero_reg, zero_next;
    logic                       out_valid_reg, out_valid_next;

    // Datapath registers
    logic [VW-1:0]              ma_reg, ma_next;
    logic [VW-1:0]              mb_reg, mb_next;
    logic                       neg_reg, neg_next;
    logic [VW-1:0]              pp_reg, pp_next;
    logic [PW-1:0]              prod_reg, prod_next;
    logic [VW-1:0]              sp_reg, sp_next;
    logic [VW-1:0]              acc_reg, acc_next;
    logic [clsc_pkg::STAT_W-1:0] status_reg, status_next;

    // Combinational helpers
    clsc_pkg::ctrl_t   cw;
    logic              in_xfer;
    logic              mat_we, x_we, b_we;
    logic [CNT_W-1:0]  eff_m, eff_n;
    logic [CNT_W-1:0]  i_inc, j_inc;
    logic              dim_zero;
    logic              cond_hit;
    logic              out_free;
    logic [VW-1:0]     vec_op;
    logic [HW-1:0]     op_a_half, op_b_half;
    logic [VW-1:0]     limit;
    logic              mul_ovf;
    logic [VW-1:0]     sum;
    logic              sum_ovf;
    logic [VW-1:0]     diff;
    logic              diff_ovf;
    logic [clsc_pkg::STAT_W-1:0] final_status;

    assign cw        = clsc_pkg::ucode(upc_reg);
    assign in_ready  = (upc_reg == clsc_pkg::UPC_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Decode store writes, dropping indexes beyond each store
    assign mat_we = in_xfer && (mode == clsc_pkg::MODE_WR_A)
                    && (32'(element_index) < MAT_DEPTH);
    assign x_we   = in_xfer && (mode == clsc_pkg::MODE_WR_X)
                    && (32'(element_index) < MAX_COLS);
    assign b_we   = in_xfer && (mode == clsc_pkg::MODE_WR_B)
                    && (32'(element_index) < MAX_ROWS);

    // Clamp dimensions to the store sizes
    always_comb
    begin
        if (32'(row_count_reg) > MAX_ROWS)
            eff_m = CNT_W'(MAX_ROWS);
        else
            eff_m = CNT_W'(row_count_reg);
        if (32'(col_count_reg) > MAX_COLS)
            eff_n = CNT_W'(MAX_COLS);
        else
            eff_n = CNT_W'(col_count_reg);
    end

    assign dim_zero = (row_count_reg == '0) || (col_count_reg == '0);
    assign i_inc    = i_reg + CNT_W'(1);
    assign j_inc    = j_reg + CNT_W'(1);

    // Evaluate the branch condition of the current step
    always_comb
    begin
        case (cw.cond)
            clsc_pkg::COND_DIM_ZERO: cond_hit = dim_zero;
            clsc_pkg::COND_J_MORE_N: cond_hit = (j_inc != eff_n);
            clsc_pkg::COND_J_MORE_M: cond_hit = (j_inc != eff_m);
            clsc_pkg::COND_I_MORE_M: cond_hit = (i_inc != eff_m);
            clsc_pkg::COND_I_MORE_N: cond_hit = (i_inc != eff_n);
            default:                 cond_hit = 1'b0;
        endcase
    end

    // Select multiplier operand halves
    assign vec_op    = (cw.vsel == clsc_pkg::VSEL_R) ? r_rd_reg : x_rd_reg;
    assign op_a_half = (cw.half == clsc_pkg::HALF_HL || cw.half == clsc_pkg::HALF_HH)
                       ? ma_reg[VW-1:HW] : ma_reg[HW-1:0];
    assign op_b_half = (cw.half == clsc_pkg::HALF_LH || cw.half == clsc_pkg::HALF_HH)
                       ? mb_reg[VW-1:HW] : mb_reg[HW-1:0];

    // Range check of the magnitude product against the signed limit
    assign limit   = neg_reg ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    assign mul_ovf = (prod_reg[PW-1:VW] != '0) || (prod_reg[VW-1:0] > limit);

    // Checked accumulate and residual difference
    assign sum      = acc_reg + sp_reg;
    assign sum_ovf  = (acc_reg[VW-1] == sp_reg[VW-1]) && (sum[VW-1] != acc_reg[VW-1]);
    assign diff     = acc_reg - b_rd_reg;
    assign diff_ovf = (acc_reg[VW-1] != b_rd_reg[VW-1]) && (diff[VW-1] != acc_reg[VW-1]);

    always_comb
    begin
        if (dim_zero)
            final_status = clsc_pkg::STAT_DIM;
        else if (ovf_reg)
            final_status = clsc_pkg::STAT_OVF;
        else if (zero_reg)
            final_status = clsc_pkg::STAT_OK;
        else
            final_status = clsc_pkg::STAT_FAIL;
    end

    // Sequencer and datapath next state
    always_comb
    begin
        upc_next       = upc_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        addr_next      = addr_reg;
        ovf_next       = ovf_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        neg_next       = neg_reg;
        pp_next        = VW'(op_a_half) * VW'(op_b_half);
        prod_next      = prod_reg;
        sp_next        = sp_reg;
        acc_next       = acc_reg;
        status_next    = status_reg;

        // Drop a taken result
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        // Advance the step counter
        if (upc_reg == clsc_pkg::UPC_IDLE)
        begin
            if (in_xfer && (mode == clsc_pkg::MODE_CHECK))
                upc_next = clsc_pkg::UPC_START;
        end
        else if (cw.done)
        begin
            if (out_free)
            begin
                upc_next       = clsc_pkg::UPC_IDLE;
                out_valid_next = 1'b1;
                status_next    = final_status;
            end
        end
        else if (cond_hit)
            upc_next = cw.target;
        else
            upc_next = upc_reg + clsc_pkg::UPC_W'(1);

        // Loop counters
        if (cw.clr_i)
            i_next = '0;
        else if (cw.inc_i)
            i_next = i_inc;
        if (cw.clr_j)
            j_next = '0;
        else if (cw.inc_j)
            j_next = j_inc;

        // Matrix address walk
        case (cw.addr_op)
            clsc_pkg::ADDR_ZERO:  addr_next = '0;
            clsc_pkg::ADDR_INC1:  addr_next = addr_reg + MA_W'(1);
            clsc_pkg::ADDR_SET_I: addr_next = MA_W'(i_reg);
            clsc_pkg::ADDR_ADD_N: addr_next = addr_reg + MA_W'(eff_n);
            default:              addr_next = addr_reg;
        endcase

        // Latch operand magnitudes and the product sign
        if (cw.ld)
        begin
            ma_next  = mat_rd_reg[VW-1] ? (VW'(0) - mat_rd_reg) : mat_rd_reg;
            mb_next  = vec_op[VW-1] ? (VW'(0) - vec_op) : vec_op;
            neg_next = mat_rd_reg[VW-1] ^ vec_op[VW-1];
        end

        // Build the magnitude product from partial products
        case (cw.prod_op)
            clsc_pkg::PROD_CLR:   prod_next = '0;
            clsc_pkg::PROD_ADD0:  prod_next = prod_reg + PW'(pp_reg);
            clsc_pkg::PROD_ADD32: prod_next = prod_reg + (PW'(pp_reg) << HW);
            clsc_pkg::PROD_ADD64: prod_next = prod_reg + (PW'(pp_reg) << VW);
            default:              prod_next = prod_reg;
        endcase

        // Restore the sign and flag an out-of-range product
        if (cw.sgn)
        begin
            sp_next = neg_reg ? (VW'(0) - prod_reg[VW-1:0]) : prod_reg[VW-1:0];
            if (mul_ovf)
                ovf_next = 1'b1;
        end

        // Accumulate
        if (cw.clr_acc)
            acc_next = '0;
        else if (cw.acc_add)
        begin
            acc_next = sum;
            if (sum_ovf)
                ovf_next = 1'b1;
        end

        if (cw.res_wr && diff_ovf)
            ovf_next = 1'b1;

        if (cw.nz_chk && (acc_reg != '0))
            zero_next = 1'b0;

        // Clear sticky flags at the start of a check
        if (cw.clr_flags)
        begin
            ovf_next  = 1'b0;
            zero_next = 1'b1;
        end
    end

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= clsc_pkg::UPC_IDLE;
            row_count_reg <= clsc_pkg::CFG_W'(1);
            col_count_reg <= clsc_pkg::CFG_W'(1);
            i_reg         <= '0;
            j_reg         <= '0;
            addr_reg      <= '0;
            ovf_reg       <= 1'b0;
            zero_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            addr_reg      <= addr_next;
            ovf_reg       <= ovf_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    clsc_pkg::CFG_ROWS: row_count_reg <= cfg_data;
                    clsc_pkg::CFG_COLS: col_count_reg <= cfg_data;
                    default:            row_count_reg <= row_count_reg;
                endcase
            end
        end
    end

    // Hold datapath payload
    always_ff @(posedge clk)
    begin
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        neg_reg    <= neg_next;
        pp_reg     <= pp_next;
        prod_reg   <= prod_next;
        sp_reg     <= sp_next;
        acc_reg    <= acc_next;
        status_reg <= status_next;
    end

    // Matrix store
    always_ff @(posedge clk)
    begin
        if (mat_we)
            mat_mem[MA_W'(element_index)] <= element_value;
        mat_rd_reg <= mat_mem[addr_reg];
    end

    // Unknown vector store
    always_ff @(posedge clk)
    begin
        if (x_we)
            x_mem[XA_W'(element_index)] <= element_value;
        x_rd_reg <= x_mem[XA_W'(j_reg)];
    end

    // Target vector store
    always_ff @(posedge clk)
    begin
        if (b_we)
            b_mem[RA_W'(element_index)] <= element_value;
        b_rd_reg <= b_mem[RA_W'(i_reg)];
    end

    // Residual store
    always_ff @(posedge clk)
    begin
        if (cw.res_wr)
            r_mem[RA_W'(i_reg)] <= diff;
        r_rd_reg <= r_mem[RA_W'(j_reg)];
    end

endmodule
